// ===== design/uowr_pkg.sv =====
// ---------------------------------------------------------------------------
// uowr_pkg: shared types and constants for the usage odometer core
// Mode and status codes, stream payload layouts, minute divide helper.
// ---------------------------------------------------------------------------
package uowr_pkg;

   localparam int unsigned RING_SLOTS_DEFAULT = 8;
   localparam logic [31:0] INTERVAL_RESET     = 32'd120000;
   localparam logic [31:0] MS_PER_MINUTE      = 32'd60000;

   // x / 60000 == (x >> 5) / 1875; reciprocal is exact for 27-bit dividends
   localparam logic [27:0] RECIP_1875 = 28'd146601551;
   localparam int unsigned RECIP_SHIFT = 38;

   localparam int unsigned REQ_W    = 152;
   localparam int unsigned RSP_W    = 152;
   localparam int unsigned MODE_W   = 4;

   typedef enum logic [3:0] {
      MODE_INIT_BEGIN  = 4'd0,
      MODE_INIT_SLOT   = 4'd1,
      MODE_TICK        = 4'd2,
      MODE_SCAN_START  = 4'd3,
      MODE_SCAN_FINISH = 4'd4,
      MODE_RESET_SYS   = 4'd5,
      MODE_RESET_LASER = 4'd6,
      MODE_RESET_BOTH  = 4'd7,
      MODE_QUERY       = 4'd8
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_READY = 2'd1,
      ST_WR_FAIL   = 2'd2
   } status_type;

   // request tdata, MSB first
   typedef struct packed {
      logic        write_ok;
      logic        store_present;
      logic [31:0] record_pulses;
      logic [31:0] record_minutes;
      logic [15:0] record_seq;
      logic        record_valid;
      logic [31:0] pulse_count;
      logic [31:0] now_ms;
   } req_type;

   // response tdata, MSB first
   typedef struct packed {
      logic        ready_res;
      logic [31:0] live_pulses;
      logic [31:0] live_minutes;
      logic [31:0] write_pulses;
      logic [31:0] write_minutes;
      logic [15:0] write_seq;
      logic [2:0]  write_slot;
      logic        write_request;
      logic [1:0]  status;
   } rsp_type;

   localparam int unsigned REQ_USED_W = $bits(req_type);
   localparam int unsigned RSP_USED_W = $bits(rsp_type);

   // whole minutes in a millisecond span
   function automatic logic [31:0] ms_to_minutes(input logic [31:0] ms);
      logic [54:0] prod;
      prod = 55'(ms[31:5]) * 55'(RECIP_1875);
      return {15'd0, prod[54:RECIP_SHIFT]};
   endfunction

endpackage

// ===== design/usage_odometer_wear_ring_core.sv =====
// ---------------------------------------------------------------------------
// usage_odometer_wear_ring_core: system-minutes and laser-pulse odometer
// Tracks both totals and emits snapshot write requests into a slot ring.
// ---------------------------------------------------------------------------
// One response per request. Each request is held in an input register, then a
// single pass of logic (one 27x28 reciprocal multiply for the minute
// divide, 32-bit adds and compares) updates the odometer state and loads the
// response register; one request per cycle is sustained
// while the response side keeps taking transfers. Start-up is an init_begin
// request followed by one init_slot request per ring slot; slot writes only
// advance the ring cursor when the request's write_ok bit is set.
module usage_odometer_wear_ring_core #(
   parameter int unsigned RING_SLOTS = uowr_pkg::RING_SLOTS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // now_ms[31:0], pulse_count[63:32], record_valid[64], record_seq[80:65],
   // record_minutes[112:81], record_pulses[144:113], store_present[145],
   // write_ok[146], zero fill above
   input  logic [uowr_pkg::REQ_W-1:0] req_tdata,
   // mode[3:0]
   input  logic [uowr_pkg::MODE_W-1:0] req_tuser,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // status[1:0], write_request[2], write_slot[5:3], write_seq[21:6],
   // write_minutes[53:22], write_pulses[85:54], live_minutes[117:86],
   // live_pulses[149:118], ready_res[150], zero fill above
   output logic [uowr_pkg::RSP_W-1:0] rsp_tdata,
   input  logic                       csr_wen,
   input  logic [31:0]                csr_wdata
);

   localparam int unsigned SLOT_W = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_SLOTS - 1);

   // pipeline registers
   logic                             in_v_ff;
   logic [uowr_pkg::REQ_USED_W-1:0]  in_data_ff;
   logic [uowr_pkg::MODE_W-1:0]      in_mode_ff;
   logic                             rsp_v_ff;
   uowr_pkg::rsp_type                rsp_ff, rsp_in;
   logic                             adv;

   // odometer state
   logic [31:0]       interval_ff;
   logic [31:0]       min_tot_ff, min_tot_in;
   logic [31:0]       pul_tot_ff, pul_tot_in;
   logic [31:0]       last_upd_ff, last_upd_in;
   logic [31:0]       scan_start_ff, scan_start_in;
   logic [SLOT_W-1:0] newest_slot_ff, newest_slot_in;
   logic              newest_vld_ff, newest_vld_in;
   logic [15:0]       newest_seq_ff, newest_seq_in;
   logic              init_ff, init_in;
   logic              store_ok_ff, store_ok_in;
   logic [SLOT_W-1:0] scan_idx_ff, scan_idx_in;
   logic              best_found_ff, best_found_in;
   logic [15:0]       best_seq_ff, best_seq_in;
   logic [SLOT_W-1:0] best_slot_ff, best_slot_in;
   logic [31:0]       best_min_ff, best_min_in;
   logic [31:0]       best_pul_ff, best_pul_in;

   uowr_pkg::req_type req;
   logic [31:0]       span_min;
   logic [SLOT_W-1:0] pers_slot;
   logic [15:0]       pers_seq;
   logic [15:0]       seq_diff;
   logic [SLOT_W+2:0] slot_ext;

   assign req        = uowr_pkg::req_type'(in_data_ff);
   assign adv        = in_v_ff && (!rsp_v_ff || rsp_tready);
   assign req_tready = !in_v_ff || adv;
   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {(uowr_pkg::RSP_W - uowr_pkg::RSP_USED_W)'(0), rsp_ff};

   assign span_min  = uowr_pkg::ms_to_minutes(req.now_ms - last_upd_ff);
   assign pers_slot = !newest_vld_ff            ? '0 :
                      (newest_slot_ff == LAST_SLOT) ? '0 :
                      newest_slot_ff + SLOT_W'(1);
   assign pers_seq  = newest_seq_ff + 16'd1;
   assign seq_diff  = req.record_seq - best_seq_ff;
   assign slot_ext  = {3'd0, pers_slot};

   always_comb begin
      logic do_persist;
      logic lu_set;
      logic fin_scan;

      do_persist     = 1'b0;
      lu_set         = 1'b0;
      fin_scan       = 1'b0;
      min_tot_in     = min_tot_ff;
      pul_tot_in     = pul_tot_ff;
      last_upd_in    = last_upd_ff;
      scan_start_in  = scan_start_ff;
      newest_slot_in = newest_slot_ff;
      newest_vld_in  = newest_vld_ff;
      newest_seq_in  = newest_seq_ff;
      init_in        = init_ff;
      store_ok_in    = store_ok_ff;
      scan_idx_in    = scan_idx_ff;
      best_found_in  = best_found_ff;
      best_seq_in    = best_seq_ff;
      best_slot_in   = best_slot_ff;
      best_min_in    = best_min_ff;
      best_pul_in    = best_pul_ff;
      rsp_in         = '0;
      rsp_in.status  = uowr_pkg::ST_OK;

      case (in_mode_ff)
         uowr_pkg::MODE_INIT_BEGIN: begin
            min_tot_in     = '0;
            pul_tot_in     = '0;
            last_upd_in    = '0;
            scan_start_in  = '0;
            newest_slot_in = '0;
            newest_vld_in  = 1'b0;
            newest_seq_in  = '0;
            init_in        = 1'b0;
            store_ok_in    = req.store_present;
            scan_idx_in    = '0;
            best_found_in  = 1'b0;
            best_seq_in    = '0;
            best_slot_in   = '0;
            best_min_in    = '0;
            best_pul_in    = '0;
            rsp_in.status  = req.store_present ? uowr_pkg::ST_OK : uowr_pkg::ST_NOT_READY;
         end
         uowr_pkg::MODE_INIT_SLOT: begin
            if (!store_ok_ff || init_ff) begin
               rsp_in.status = uowr_pkg::ST_NOT_READY;
            end else begin
               if (req.record_valid &&
                   (!best_found_ff || (seq_diff != 16'd0 && !seq_diff[15]))) begin
                  best_found_in = 1'b1;
                  best_seq_in   = req.record_seq;
                  best_slot_in  = scan_idx_ff;
                  best_min_in   = req.record_minutes;
                  best_pul_in   = req.record_pulses;
               end
               if (scan_idx_ff == LAST_SLOT) begin
                  fin_scan = 1'b1;
                  if (best_found_in) begin
                     min_tot_in     = best_min_in;
                     pul_tot_in     = best_pul_in;
                     newest_slot_in = best_slot_in;
                     newest_seq_in  = best_seq_in;
                     newest_vld_in  = 1'b1;
                  end else begin
                     do_persist = 1'b1;
                  end
                  init_in       = 1'b1;
                  last_upd_in   = req.now_ms;
                  lu_set        = 1'b1;
                  scan_start_in = '0;
               end else begin
                  scan_idx_in = scan_idx_ff + SLOT_W'(1);
               end
            end
         end
         uowr_pkg::MODE_TICK, uowr_pkg::MODE_SCAN_START, uowr_pkg::MODE_SCAN_FINISH,
         uowr_pkg::MODE_RESET_SYS, uowr_pkg::MODE_RESET_LASER,
         uowr_pkg::MODE_RESET_BOTH: begin
            if (!init_ff) begin
               rsp_in.status = uowr_pkg::ST_NOT_READY;
            end else begin
               case (in_mode_ff)
                  uowr_pkg::MODE_TICK: begin
                     if ((req.now_ms - last_upd_ff) >= interval_ff) begin
                        min_tot_in  = min_tot_ff + span_min;
                        last_upd_in = req.now_ms;
                        lu_set      = 1'b1;
                        do_persist  = 1'b1;
                     end
                  end
                  uowr_pkg::MODE_SCAN_START: begin
                     scan_start_in = req.pulse_count;
                  end
                  uowr_pkg::MODE_SCAN_FINISH: begin
                     pul_tot_in = pul_tot_ff + (req.pulse_count - scan_start_ff);
                     do_persist = 1'b1;
                     if (req.write_ok) begin
                        scan_start_in = '0;
                     end
                  end
                  default: begin
                     // reset modes
                     if (in_mode_ff == uowr_pkg::MODE_RESET_SYS ||
                         in_mode_ff == uowr_pkg::MODE_RESET_BOTH) begin
                        min_tot_in  = '0;
                        last_upd_in = req.now_ms;
                        lu_set      = 1'b1;
                     end
                     if (in_mode_ff == uowr_pkg::MODE_RESET_LASER ||
                         in_mode_ff == uowr_pkg::MODE_RESET_BOTH) begin
                        pul_tot_in    = '0;
                        scan_start_in = '0;
                     end
                     do_persist = 1'b1;
                  end
               endcase
            end
         end
         default: begin
            // query and unused codes
            rsp_in.status = init_ff ? uowr_pkg::ST_OK : uowr_pkg::ST_NOT_READY;
         end
      endcase

      if (do_persist) begin
         rsp_in.write_request = 1'b1;
         rsp_in.write_slot    = slot_ext[2:0];
         rsp_in.write_seq     = pers_seq;
         rsp_in.write_minutes = min_tot_in;
         rsp_in.write_pulses  = pul_tot_in;
         if (req.write_ok) begin
            newest_slot_in = pers_slot;
            newest_seq_in  = pers_seq;
            newest_vld_in  = 1'b1;
            rsp_in.status  = uowr_pkg::ST_OK;
         end else begin
            rsp_in.status  = uowr_pkg::ST_WR_FAIL;
         end
      end

      // last update moved to now: no whole minutes pending
      if (init_in) begin
         rsp_in.live_minutes = min_tot_in + (lu_set ? 32'd0 : span_min);
         rsp_in.live_pulses  = pul_tot_in;
         rsp_in.ready_res    = 1'b1;
      end
      if (fin_scan) begin
         scan_idx_in = scan_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff        <= 1'b0;
         rsp_v_ff       <= 1'b0;
         interval_ff    <= uowr_pkg::INTERVAL_RESET;
         min_tot_ff     <= '0;
         pul_tot_ff     <= '0;
         last_upd_ff    <= '0;
         scan_start_ff  <= '0;
         newest_slot_ff <= '0;
         newest_vld_ff  <= 1'b0;
         newest_seq_ff  <= '0;
         init_ff        <= 1'b0;
         store_ok_ff    <= 1'b0;
         scan_idx_ff    <= '0;
         best_found_ff  <= 1'b0;
         best_seq_ff    <= '0;
         best_slot_ff   <= '0;
         best_min_ff    <= '0;
         best_pul_ff    <= '0;
      end else begin
         if (csr_wen) begin
            interval_ff <= csr_wdata;
         end
         if (req_tready) begin
            in_v_ff <= req_tvalid;
         end
         if (adv) begin
            rsp_v_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_v_ff <= 1'b0;
         end
         if (adv) begin
            min_tot_ff     <= min_tot_in;
            pul_tot_ff     <= pul_tot_in;
            last_upd_ff    <= last_upd_in;
            scan_start_ff  <= scan_start_in;
            newest_slot_ff <= newest_slot_in;
            newest_vld_ff  <= newest_vld_in;
            newest_seq_ff  <= newest_seq_in;
            init_ff        <= init_in;
            store_ok_ff    <= store_ok_in;
            scan_idx_ff    <= scan_idx_in;
            best_found_ff  <= best_found_in;
            best_seq_ff    <= best_seq_in;
            best_slot_ff   <= best_slot_in;
            best_min_ff    <= best_min_in;
            best_pul_ff    <= best_pul_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_data_ff <= req_tdata[uowr_pkg::REQ_USED_W-1:0];
         in_mode_ff <= req_tuser;
      end
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   // a write request only leaves the block once the odometer is running
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_ff.write_request |-> rsp_ff.ready_res)
      else $error("write request while odometer not ready");

   // no write request means an all-zero record field set
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_ff.write_request |->
         rsp_ff.write_slot == 3'd0 && rsp_ff.write_seq == 16'd0 &&
         rsp_ff.write_minutes == 32'd0 && rsp_ff.write_pulses == 32'd0)
      else $error("record fields set without write request");

   // ring cursor and scan index stay inside the ring
   assert property (@(posedge clock) disable iff (reset)
      newest_slot_ff <= LAST_SLOT && scan_idx_ff <= LAST_SLOT)
      else $error("slot index beyond ring");

   // a write failure is reported only with a write request
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_ff.status == uowr_pkg::ST_WR_FAIL |-> rsp_ff.write_request)
      else $error("write failure without write request");

endmodule

// ===== sim/tb_usage_odometer_wear_ring_core.sv =====
// ---------------------------------------------------------------------------
// tb_usage_odometer_wear_ring_core: self-checking bench for the odometer core
// A short directed script covers start-up, the not-ready paths and field
// extremes, followed by random event streams under several persist intervals.
// Every response is compared field by field against a scripted expectation
// or a cycle-free model of the odometer, with random idle gaps on both streams.
// ---------------------------------------------------------------------------
module tb_usage_odometer_wear_ring_core;

   localparam int unsigned SLOTS       = uowr_pkg::RING_SLOTS_DEFAULT;
   localparam int          PHASE_ITEMS = 238;
   localparam int          HOLD_CYCLES = 300;
   localparam logic [3:0]  MODE_FIRST_UNUSED = 4'd9;
   localparam logic [3:0]  MODE_LAST_UNUSED  = 4'hF;

   typedef struct packed {
      logic [3:0]        mode;
      uowr_pkg::req_type req;
      logic              typed;
      uowr_pkg::rsp_type want;
   } script_row_type;

   logic                          clock;
   logic                          reset;
   logic                          req_tvalid;
   logic                          req_tready;
   logic [uowr_pkg::REQ_W-1:0]    req_tdata;
   logic [uowr_pkg::MODE_W-1:0]   req_tuser;
   logic                          rsp_tvalid;
   logic                          rsp_tready;
   logic [uowr_pkg::RSP_W-1:0]    rsp_tdata;
   logic                          csr_wen;
   logic [31:0]                   csr_wdata;

   // odometer model state
   logic [31:0] interval_ms;
   logic [31:0] odo_minutes, odo_pulses, odo_stamp_ms, scan_base;
   logic [31:0] ring_head;
   logic        ring_head_valid;
   logic [15:0] ring_seq;
   logic        odo_ready, store_seen;
   logic [31:0] probe_index;
   logic        cand_found;
   logic [15:0] cand_seq;
   logic [31:0] cand_slot, cand_minutes, cand_pulses;

   uowr_pkg::rsp_type pending_rsp[$];
   script_row_type    script[$];
   int                sent_count, got_count, mismatches;
   logic              tx_burst, rx_burst;
   logic [31:0]       sim_ms, sim_pulse;
   uowr_pkg::rsp_type want_rsp, seen_rsp;

   usage_odometer_wear_ring_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------- model
   function automatic logic [1:0] ring_write(input logic ok, inout uowr_pkg::rsp_type y);
      logic [31:0] slot;
      logic [15:0] seq;
      slot = ring_head_valid ? (ring_head + 1) % SLOTS : 32'd0;
      seq  = ring_seq + 16'd1;
      y.write_request = 1'b1;
      y.write_slot    = slot[2:0];
      y.write_seq     = seq;
      y.write_minutes = odo_minutes;
      y.write_pulses  = odo_pulses;
      if (!ok)
         return uowr_pkg::ST_WR_FAIL;
      ring_head       = slot;
      ring_seq        = seq;
      ring_head_valid = 1'b1;
      return uowr_pkg::ST_OK;
   endfunction

   function automatic uowr_pkg::rsp_type odometer_predict(input logic [3:0] mode,
                                                          input uowr_pkg::req_type r);
      uowr_pkg::rsp_type y;
      logic [31:0]       elapsed;
      logic [15:0]       seq_gap;
      logic [1:0]        st;
      y  = '0;
      st = uowr_pkg::ST_OK;
      if (mode == uowr_pkg::MODE_INIT_BEGIN) begin
         odo_minutes     = '0;
         odo_pulses      = '0;
         odo_stamp_ms    = '0;
         scan_base       = '0;
         ring_head       = '0;
         ring_head_valid = 1'b0;
         ring_seq        = '0;
         odo_ready       = 1'b0;
         store_seen      = r.store_present;
         probe_index     = '0;
         cand_found      = 1'b0;
         cand_seq        = '0;
         cand_slot       = '0;
         cand_minutes    = '0;
         cand_pulses     = '0;
         st = r.store_present ? uowr_pkg::ST_OK : uowr_pkg::ST_NOT_READY;
      end else if (mode == uowr_pkg::MODE_INIT_SLOT) begin
         if (!store_seen || odo_ready) begin
            st = uowr_pkg::ST_NOT_READY;
         end else begin
            // newest record wins, sequence compared modulo 2^16
            seq_gap = r.record_seq - cand_seq;
            if (r.record_valid &&
                (!cand_found || (seq_gap != 16'd0 && seq_gap < 16'h8000))) begin
               cand_found   = 1'b1;
               cand_seq     = r.record_seq;
               cand_slot    = probe_index;
               cand_minutes = r.record_minutes;
               cand_pulses  = r.record_pulses;
            end
            if (probe_index + 1 >= SLOTS) begin
               if (cand_found) begin
                  odo_minutes     = cand_minutes;
                  odo_pulses      = cand_pulses;
                  ring_head       = cand_slot;
                  ring_seq        = cand_seq;
                  ring_head_valid = 1'b1;
               end else begin
                  st = ring_write(r.write_ok, y);
               end
               odo_ready    = 1'b1;
               odo_stamp_ms = r.now_ms;
               scan_base    = '0;
            end else begin
               probe_index = probe_index + 1;
            end
         end
      end else if (mode >= uowr_pkg::MODE_TICK && mode <= uowr_pkg::MODE_RESET_BOTH) begin
         if (!odo_ready) begin
            st = uowr_pkg::ST_NOT_READY;
         end else if (mode == uowr_pkg::MODE_TICK) begin
            elapsed = r.now_ms - odo_stamp_ms;
            if (elapsed >= interval_ms) begin
               odo_minutes  = odo_minutes + elapsed / uowr_pkg::MS_PER_MINUTE;
               odo_stamp_ms = r.now_ms;
               st = ring_write(r.write_ok, y);
            end
         end else if (mode == uowr_pkg::MODE_SCAN_START) begin
            scan_base = r.pulse_count;
         end else if (mode == uowr_pkg::MODE_SCAN_FINISH) begin
            odo_pulses = odo_pulses + (r.pulse_count - scan_base);
            st = ring_write(r.write_ok, y);
            if (st == uowr_pkg::ST_OK)
               scan_base = '0;
         end else begin
            if (mode == uowr_pkg::MODE_RESET_SYS || mode == uowr_pkg::MODE_RESET_BOTH) begin
               odo_minutes  = '0;
               odo_stamp_ms = r.now_ms;
            end
            if (mode == uowr_pkg::MODE_RESET_LASER || mode == uowr_pkg::MODE_RESET_BOTH) begin
               odo_pulses = '0;
               scan_base  = '0;
            end
            st = ring_write(r.write_ok, y);
         end
      end else begin
         st = odo_ready ? uowr_pkg::ST_OK : uowr_pkg::ST_NOT_READY;
      end
      y.status = st;
      if (odo_ready) begin
         elapsed        = r.now_ms - odo_stamp_ms;
         y.live_minutes = odo_minutes + elapsed / uowr_pkg::MS_PER_MINUTE;
         y.live_pulses  = odo_pulses;
         y.ready_res    = 1'b1;
      end
      return y;
   endfunction

   // ------------------------------------------------------------ stimulus
   function automatic uowr_pkg::req_type make_req(input logic [31:0] now, pulse,
                                                  input logic rvalid,
                                                  input logic [15:0] rseq,
                                                  input logic [31:0] rmin, rpul,
                                                  input logic present, wok);
      uowr_pkg::req_type r;
      r.now_ms         = now;
      r.pulse_count    = pulse;
      r.record_valid   = rvalid;
      r.record_seq     = rseq;
      r.record_minutes = rmin;
      r.record_pulses  = rpul;
      r.store_present  = present;
      r.write_ok       = wok;
      return r;
   endfunction

   function automatic uowr_pkg::rsp_type make_rsp(input logic [1:0] st, input logic wreq,
                                                  input logic [2:0] slot,
                                                  input logic [15:0] seq,
                                                  input logic [31:0] wmin, wpul, lmin, lpul,
                                                  input logic rdy);
      uowr_pkg::rsp_type y;
      y.status        = st;
      y.write_request = wreq;
      y.write_slot    = slot;
      y.write_seq     = seq;
      y.write_minutes = wmin;
      y.write_pulses  = wpul;
      y.live_minutes  = lmin;
      y.live_pulses   = lpul;
      y.ready_res     = rdy;
      return y;
   endfunction

   function automatic uowr_pkg::req_type random_req();
      uowr_pkg::req_type r;
      r.now_ms         = $urandom;
      r.pulse_count    = $urandom;
      r.record_valid   = 1'($urandom_range(0, 1));
      r.record_seq     = 16'($urandom);
      r.record_minutes = $urandom;
      r.record_pulses  = $urandom;
      r.store_present  = $urandom_range(0, 99) < 90;
      r.write_ok       = $urandom_range(0, 99) < 85;
      return r;
   endfunction

   task automatic add_step(input logic [3:0] mode, input uowr_pkg::req_type r,
                           input logic typed, input uowr_pkg::rsp_type want);
      script_row_type row;
      row.mode  = mode;
      row.req   = r;
      row.typed = typed;
      row.want  = want;
      script.push_back(row);
   endtask

   // one transfer on the request side; the expectation is queued at acceptance
   task automatic send_item(input logic [3:0] mode, input uowr_pkg::req_type r,
                            input logic typed, input uowr_pkg::rsp_type want);
      int                gap;
      uowr_pkg::rsp_type predicted;
      if (sent_count % 64 == 0)
         tx_burst = ($urandom_range(0, 3) == 0);
      if (tx_burst)
         gap = 0;
      else if ($urandom_range(0, 99) < 55)
         gap = 0;
      else if ($urandom_range(0, 99) < 85)
         gap = $urandom_range(1, 3);
      else
         gap = $urandom_range(6, 40);
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {{(uowr_pkg::REQ_W - uowr_pkg::REQ_USED_W){1'b0}}, r};
      req_tuser  <= mode;
      do @(posedge clock); while (!req_tready);
      predicted = odometer_predict(mode, r);
      pending_rsp.push_back(typed ? want : predicted);
      sent_count++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (got_count != sent_count) @(posedge clock);
   endtask

   task automatic write_interval(input logic [31:0] value);
      wait_drained();
      repeat (3) @(posedge clock);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_wen   <= 1'b0;
      interval_ms = value;
   endtask

   // init_begin plus slot reads; slots < SLOTS leaves a broken scan behind
   task automatic run_init(input logic present, input int slots);
      uowr_pkg::req_type r;
      int                scheme, head, k;
      logic [15:0]       base;
      r = random_req();
      r.store_present = present;
      r.now_ms = sim_ms;
      send_item(uowr_pkg::MODE_INIT_BEGIN, r, 1'b0, '0);
      scheme = $urandom_range(0, 9);
      base   = ($urandom_range(0, 3) == 0) ? 16'hFFFF - 16'($urandom_range(0, 8))
                                           : 16'($urandom);
      head   = $urandom_range(0, SLOTS - 1);
      for (k = 0; k < slots; k++) begin
         r = random_req();
         sim_ms = sim_ms + $urandom_range(0, 50);
         r.now_ms = sim_ms;
         if (scheme == 0) begin
            r.record_valid = 1'b0;
         end else if (scheme <= 3) begin
            r.record_valid = $urandom_range(0, 99) < 80;
         end else if (scheme == 4) begin
            r.record_seq = base;
         end else begin
            // ring as written in normal use: head holds the newest record
            r.record_seq   = (k <= head) ? base + 16'(k) : base + 16'(k) - 16'(SLOTS);
            r.record_valid = $urandom_range(0, 99) < 90;
         end
         send_item(uowr_pkg::MODE_INIT_SLOT, r, 1'b0, '0);
      end
   endtask

   task automatic random_event();
      uowr_pkg::req_type r;
      int                pick, step;
      logic [3:0]        mode;
      r = random_req();
      pick = $urandom_range(0, 99);
      if (pick < 40)
         mode = uowr_pkg::MODE_TICK;
      else if (pick < 52)
         mode = uowr_pkg::MODE_SCAN_START;
      else if (pick < 64)
         mode = uowr_pkg::MODE_SCAN_FINISH;
      else if (pick < 68)
         mode = uowr_pkg::MODE_RESET_SYS;
      else if (pick < 72)
         mode = uowr_pkg::MODE_RESET_LASER;
      else if (pick < 76)
         mode = uowr_pkg::MODE_RESET_BOTH;
      else if (pick < 86)
         mode = uowr_pkg::MODE_QUERY;
      else if (pick < 91)
         mode = 4'($urandom_range(MODE_FIRST_UNUSED, MODE_LAST_UNUSED));
      else if (pick < 94)
         mode = uowr_pkg::MODE_INIT_SLOT;
      else
         mode = uowr_pkg::MODE_INIT_BEGIN;
      if (mode == uowr_pkg::MODE_INIT_BEGIN) begin
         run_init(r.store_present, ($urandom_range(0, 99) < 15) ? $urandom_range(0, SLOTS - 1)
                                                                  : SLOTS);
         return;
      end
      step = $urandom_range(0, 99);
      if (step < 60)
         sim_ms = sim_ms + $urandom_range(0, 30000);
      else if (step < 90)
         sim_ms = sim_ms + $urandom_range(30000, 200000);
      else if (step < 97)
         sim_ms = sim_ms + $urandom_range(200000, 2000000);
      else
         sim_ms = $urandom;
      r.now_ms = sim_ms;
      // land a tick exactly on or just short of the persist threshold
      if (mode == uowr_pkg::MODE_TICK && $urandom_range(0, 99) < 20)
         r.now_ms = odo_stamp_ms + interval_ms - 32'($urandom_range(0, 1));
      if (mode == uowr_pkg::MODE_SCAN_START) begin
         sim_pulse = ($urandom_range(0, 9) == 0) ? $urandom : sim_pulse + $urandom_range(0, 500);
         r.pulse_count = sim_pulse;
      end else if (mode == uowr_pkg::MODE_SCAN_FINISH) begin
         sim_pulse = ($urandom_range(0, 9) == 0) ? $urandom : sim_pulse + $urandom_range(0, 5000);
         r.pulse_count = sim_pulse;
      end
      send_item(mode, r, 1'b0, '0);
   endtask

   initial begin : stimulus
      logic [31:0]       plan [6];
      uowr_pkg::rsp_type not_ready, idle_ok;
      int                k, p;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      csr_wen     = 1'b0;
      csr_wdata   = '0;
      sent_count  = 0;
      got_count   = 0;
      mismatches  = 0;
      tx_burst    = 1'b0;
      sim_ms      = '0;
      sim_pulse   = '0;
      interval_ms = uowr_pkg::INTERVAL_RESET;
      void'(odometer_predict(uowr_pkg::MODE_INIT_BEGIN, '0));
      store_seen  = 1'b0;
      plan[0] = 32'd1;
      plan[1] = 32'hFFFF_FFFF;
      plan[2] = 32'd0;
      plan[3] = uowr_pkg::MS_PER_MINUTE;
      plan[4] = $urandom_range(1, 600000);
      plan[5] = uowr_pkg::INTERVAL_RESET;

      not_ready = make_rsp(uowr_pkg::ST_NOT_READY, 0, 0, 0, 0, 0, 0, 0, 0);
      idle_ok   = make_rsp(uowr_pkg::ST_OK, 0, 0, 0, 0, 0, 0, 0, 0);
      add_step(uowr_pkg::MODE_TICK, make_req(500, 0, 0, 0, 0, 0, 0, 1), 1, not_ready);
      add_step(uowr_pkg::MODE_QUERY, make_req(0, 0, 0, 0, 0, 0, 1, 1), 1, not_ready);
      add_step(uowr_pkg::MODE_INIT_SLOT, make_req(0, 0, 1, 16'd1, 5, 6, 1, 1), 1, not_ready);
      add_step(uowr_pkg::MODE_INIT_BEGIN, make_req(0, 0, 0, 0, 0, 0, 0, 1), 1, not_ready);
      add_step(uowr_pkg::MODE_INIT_SLOT, make_req(0, 0, 1, 16'd2, 3, 4, 0, 1), 1, not_ready);
      add_step(uowr_pkg::MODE_INIT_BEGIN, make_req('1, '1, 1, '1, '1, '1, 1, 0), 1, idle_ok);
      for (k = 0; k < SLOTS - 1; k++)
         add_step(uowr_pkg::MODE_INIT_SLOT, make_req('1, '1, 0, '1, '1, '1, 1, 1), 1, idle_ok);
      // empty ring: the blank record write to slot 0 fails, block still comes up
      add_step(uowr_pkg::MODE_INIT_SLOT, make_req(1000, 0, 0, 0, 0, 0, 1, 0), 1,
               make_rsp(uowr_pkg::ST_WR_FAIL, 1, 0, 16'd1, 0, 0, 0, 0, 1));
      add_step(uowr_pkg::MODE_INIT_SLOT, make_req(60999, 0, 1, 16'd7, 9, 9, 1, 1), 1,
               make_rsp(uowr_pkg::ST_NOT_READY, 0, 0, 0, 0, 0, 0, 0, 1));
      add_step(uowr_pkg::MODE_QUERY, make_req(61000, 0, 0, 0, 0, 0, 1, 1), 1,
               make_rsp(uowr_pkg::ST_OK, 0, 0, 0, 0, 0, 1, 0, 1));
      add_step(uowr_pkg::MODE_TICK, make_req(120999, 0, 0, 0, 0, 0, 1, 1), 0, '0);
      add_step(uowr_pkg::MODE_TICK, make_req('1, 0, 0, 0, 0, 0, 1, 1), 0, '0);
      add_step(uowr_pkg::MODE_SCAN_START, make_req('1, '1, 0, 0, 0, 0, 1, 1), 0, '0);
      add_step(uowr_pkg::MODE_SCAN_FINISH, make_req('1, 5, 0, 0, 0, 0, 1, 0), 0, '0);
      add_step(uowr_pkg::MODE_SCAN_FINISH, make_req('1, 0, 0, 0, 0, 0, 1, 1), 0, '0);
      add_step(uowr_pkg::MODE_RESET_SYS, make_req(0, 0, 0, 0, 0, 0, 1, 1), 0, '0);
      add_step(uowr_pkg::MODE_RESET_LASER, make_req(0, 0, 0, 0, 0, 0, 1, 1), 0, '0);
      add_step(uowr_pkg::MODE_RESET_BOTH, make_req(60000, 0, 0, 0, 0, 0, 1, 0), 0, '0);
      add_step(MODE_LAST_UNUSED, make_req(120000, 0, 0, 0, 0, 0, 1, 1), 0, '0);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (k = 0; k < script.size(); k++)
         send_item(script[k].mode, script[k].req, script[k].typed, script[k].want);

      for (p = 0; p < 6; p++) begin
         write_interval(plan[p]);
         run_init(1'b1, SLOTS);
         while (sent_count < script.size() + (p + 1) * PHASE_ITEMS)
            random_event();
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (pending_rsp.size() != 0)
         mismatches += pending_rsp.size();
      if (mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // ------------------------------------------------------------ receiver
   initial begin : receiver
      int  stall, cycles, pick;
      logic held;
      rsp_tready = 1'b0;
      rx_burst   = 1'b0;
      stall  = 0;
      cycles = 0;
      held   = 1'b0;
      forever begin
         @(negedge clock);
         cycles++;
         if (cycles % 128 == 0)
            rx_burst = ($urandom_range(0, 3) == 0);
         // one long hold-off so the request side backs up
         if (!held && got_count >= 400) begin
            held  = 1'b1;
            stall = HOLD_CYCLES;
         end else if (stall == 0 && !rx_burst) begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
               stall = $urandom_range(1, 3);
            else if (pick < 28)
               stall = $urandom_range(8, 30);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------- checker
   task automatic flag_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10)
         $display("MISMATCH at %0t: %s", $time, msg);
   endtask

   task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] seen);
      if (want !== seen)
         flag_mismatch($sformatf("%s expected %h got %h", what, want, seen));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_count++;
         seen_rsp = uowr_pkg::rsp_type'(rsp_tdata[uowr_pkg::RSP_USED_W-1:0]);
         if (pending_rsp.size() == 0) begin
            flag_mismatch($sformatf("response %h with nothing outstanding", seen_rsp));
         end else begin
            want_rsp = pending_rsp.pop_front();
            check_field("status", 32'(want_rsp.status), 32'(seen_rsp.status));
            check_field("write_request", 32'(want_rsp.write_request),
                        32'(seen_rsp.write_request));
            check_field("write_slot", 32'(want_rsp.write_slot), 32'(seen_rsp.write_slot));
            check_field("write_seq", 32'(want_rsp.write_seq), 32'(seen_rsp.write_seq));
            check_field("write_minutes", want_rsp.write_minutes, seen_rsp.write_minutes);
            check_field("write_pulses", want_rsp.write_pulses, seen_rsp.write_pulses);
            check_field("live_minutes", want_rsp.live_minutes, seen_rsp.live_minutes);
            check_field("live_pulses", want_rsp.live_pulses, seen_rsp.live_pulses);
            check_field("ready_res", 32'(want_rsp.ready_res), 32'(seen_rsp.ready_res));
         end
      end
   end

   initial begin : watchdog
      #20000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
